>>> hw/rtl/dprp_pkg.sv
package dprp_pkg;

  // parse phases
  localparam logic [1:0] PH_ENTITY   = 2'd0;
  localparam logic [1:0] PH_COMP_HDR = 2'd1;
  localparam logic [1:0] PH_DATA     = 2'd2;

  // record kinds
  localparam logic [1:0] K_WRITE   = 2'd0;
  localparam logic [1:0] K_EMPTY   = 2'd1;
  localparam logic [1:0] K_DESPAWN = 2'd2;
  localparam logic [1:0] K_END     = 2'd3;

  localparam logic [15:0] TOMBSTONE_COUNT = 16'hFFFF;
  localparam int          ENTITY_HDR_LEN  = 6;
  localparam int          COMP_HDR_LEN    = 4;
  localparam int          MASK_W          = 64;

  // record queue between parser and output stage
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] entity_id;
    logic [15:0] type_id;
    logic [15:0] byte_offset;
    logic [7:0]  data_byte;
    logic        component_last;
    logic        end_flag;
    logic        status;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } q_head_t;

endpackage

>>> hw/rtl/dprp_if.sv
interface dprp_payload_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_end;

  modport source (output valid, output payload_byte, output payload_end, input ready);
  modport sink (input valid, input payload_byte, input payload_end, output ready);
endinterface

interface dprp_record_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [31:0] entity_id;
  logic [15:0] type_id;
  logic [15:0] byte_offset;
  logic [7:0]  data_byte;
  logic        component_last;
  logic        end_flag;
  logic        status;

  modport source (output valid, output record_kind, output entity_id, output type_id,
                  output byte_offset, output data_byte, output component_last,
                  output end_flag, output status, input ready);
  modport sink (input valid, input record_kind, input entity_id, input type_id,
                input byte_offset, input data_byte, input component_last,
                input end_flag, input status, output ready);
endinterface

interface dprp_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/dprp_front.sv
module dprp_front #(
  parameter int NUM_TYPES = 64
) (
  input  logic          clk,
  input  logic          rst,
  dprp_payload_if.sink  payload,
  dprp_cfg_if.sink      cfg,
  input  logic          q_full,
  output logic          push,
  output dprp_pkg::rec_t push_rec
);
  import dprp_pkg::*;

  logic [MASK_W-1:0] client_only_mask;
  logic [1:0]  phase, phase_next;
  logic [2:0]  header_bytes, header_bytes_next;
  logic [31:0] cur_entity, cur_entity_next;
  logic [15:0] comps_left, comps_left_next;
  logic [15:0] cur_type, cur_type_next;
  logic [15:0] data_left, data_left_next;
  logic [15:0] data_offset, data_offset_next;
  logic        skip_component, skip_component_next;

  logic        accept;
  logic        emit;
  logic        type_skip;
  logic [15:0] comps_dec;
  logic [7:0]  b;
  rec_t        rec;

  assign accept        = payload.valid && payload.ready;
  assign payload.ready = !q_full;
  assign cfg.ready     = 1'b1;
  assign b             = payload.payload_byte;
  assign comps_dec     = comps_left - 16'd1;

  // types at or above the type count are always dropped
  assign type_skip = (cur_type >= 16'(NUM_TYPES)) || client_only_mask[cur_type[5:0]];

  always_comb begin
    phase_next          = phase;
    header_bytes_next   = header_bytes;
    cur_entity_next     = cur_entity;
    comps_left_next     = comps_left;
    cur_type_next       = cur_type;
    data_left_next      = data_left;
    data_offset_next    = data_offset;
    skip_component_next = skip_component;
    emit                = 1'b0;
    rec                 = '0;

    case (phase)
      PH_COMP_HDR: begin
        case (header_bytes[1:0])
          2'd0:    cur_type_next  = {8'd0, b};
          2'd1:    cur_type_next  = {b, cur_type[7:0]};
          2'd2:    data_left_next = {8'd0, b};
          default: data_left_next = {b, data_left[7:0]};
        endcase
        header_bytes_next = header_bytes + 3'd1;
        if (header_bytes == 3'(COMP_HDR_LEN - 1)) begin
          header_bytes_next   = '0;
          skip_component_next = type_skip;
          data_offset_next    = '0;
          if (data_left_next == 16'd0) begin
            if (!type_skip) begin
              emit            = 1'b1;
              rec.record_kind = K_EMPTY;
              rec.entity_id   = cur_entity;
              rec.type_id     = cur_type;
            end
            comps_left_next = comps_dec;
            phase_next      = (comps_dec == 16'd0) ? PH_ENTITY : PH_COMP_HDR;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        data_left_next = data_left - 16'd1;
        if (!skip_component) begin
          emit               = 1'b1;
          rec.record_kind    = K_WRITE;
          rec.entity_id      = cur_entity;
          rec.type_id        = cur_type;
          rec.byte_offset    = data_offset;
          rec.data_byte      = b;
          rec.component_last = (data_left_next == 16'd0);
        end
        data_offset_next = data_offset + 16'd1;
        if (data_left_next == 16'd0) begin
          header_bytes_next = '0;
          comps_left_next   = comps_dec;
          phase_next        = (comps_dec == 16'd0) ? PH_ENTITY : PH_COMP_HDR;
        end
      end
      default: begin
        // entity header; an unused phase code restarts the header
        logic [2:0] idx;
        idx        = (phase == PH_ENTITY) ? header_bytes : 3'd0;
        phase_next = PH_ENTITY;
        case (idx)
          3'd0:    cur_entity_next = {24'd0, b};
          3'd1:    cur_entity_next = {cur_entity[31:16], b, cur_entity[7:0]};
          3'd2:    cur_entity_next = {cur_entity[31:24], b, cur_entity[15:0]};
          3'd3:    cur_entity_next = {b, cur_entity[23:0]};
          3'd4:    comps_left_next = {8'd0, b};
          default: comps_left_next = {b, comps_left[7:0]};
        endcase
        header_bytes_next = idx + 3'd1;
        if (idx >= 3'(ENTITY_HDR_LEN - 1)) begin
          header_bytes_next = '0;
          if (comps_left_next == TOMBSTONE_COUNT) begin
            emit            = 1'b1;
            rec.record_kind = K_DESPAWN;
            rec.entity_id   = cur_entity_next;
            comps_left_next = '0;
          end else if (comps_left_next != 16'd0) begin
            phase_next = PH_COMP_HDR;
          end
        end
      end
    endcase

    if (payload.payload_end) begin
      if (!emit) begin
        rec             = '0;
        rec.record_kind = K_END;
      end
      emit       = 1'b1;
      rec.end_flag = 1'b1;
      rec.status   = (phase_next == PH_DATA) && (data_left_next != 16'd0);
      phase_next          = PH_ENTITY;
      header_bytes_next   = '0;
      cur_entity_next     = '0;
      comps_left_next     = '0;
      cur_type_next       = '0;
      data_left_next      = '0;
      data_offset_next    = '0;
      skip_component_next = 1'b0;
    end
  end

  assign push     = accept && emit;
  assign push_rec = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_only_mask <= '1;
      phase            <= PH_ENTITY;
      header_bytes     <= '0;
      cur_entity       <= '0;
      comps_left       <= '0;
      cur_type         <= '0;
      data_left        <= '0;
      data_offset      <= '0;
      skip_component   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        client_only_mask <= cfg.data;
      end
      if (accept) begin
        phase          <= phase_next;
        header_bytes   <= header_bytes_next;
        cur_entity     <= cur_entity_next;
        comps_left     <= comps_left_next;
        cur_type       <= cur_type_next;
        data_left      <= data_left_next;
        data_offset    <= data_offset_next;
        skip_component <= skip_component_next;
      end
    end
  end

  // a data phase always owes at least one byte
  a_data_owed: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> data_left != 16'd0)
    else $error("data phase with nothing left to read");

  // the closing byte leaves the parser in a fresh entity header
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && payload.payload_end |=> phase == PH_ENTITY && header_bytes == 3'd0
      && comps_left == 16'd0)
    else $error("parse state not cleared after payload end");

endmodule

>>> hw/rtl/dprp_queue.sv
module dprp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dprp_pkg::rec_t    push_rec,
  input  logic              pop,
  output dprp_pkg::q_head_t head,
  output logic              full
);
  import dprp_pkg::*;

  rec_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full       = (count == (Q_AW+1)'(Q_DEPTH));
  assign head.valid = (count != '0);
  assign head.rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("record queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("record queue underflow");

endmodule

>>> hw/rtl/dprp_back.sv
module dprp_back (
  input  logic                clk,
  input  logic                rst,
  input  dprp_pkg::q_head_t   head,
  output logic                pop,
  dprp_record_if.source       records
);
  import dprp_pkg::*;

  logic out_valid;
  rec_t out_rec;

  // refill the output register whenever it is empty or being taken
  assign pop = head.valid && (!out_valid || records.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || records.ready) begin
      out_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rec <= head.rec;
    end
  end

  assign records.valid          = out_valid;
  assign records.record_kind    = out_rec.record_kind;
  assign records.entity_id      = out_rec.entity_id;
  assign records.type_id        = out_rec.type_id;
  assign records.byte_offset    = out_rec.byte_offset;
  assign records.data_byte      = out_rec.data_byte;
  assign records.component_last = out_rec.component_last;
  assign records.end_flag       = out_rec.end_flag;
  assign records.status         = out_rec.status;

endmodule

>>> hw/rtl/delta_payload_record_parser.sv
// channel   | direction | carries
// ----------+-----------+-------------------------------------------------
// payload   | in        | payload_byte, payload_end (one byte per transfer)
// records   | out       | one parsed record per transfer
// cfg       | in        | client_only_mask write data, always ready
//
// one payload byte is taken every cycle while the record queue is not full;
// each accepted byte drives a byte-wide state update in the front parser
// a record goes valid once it has passed the queue write and then the output
// register load after its payload transfer; reset is synchronous, clears parse
// state and queue and sets the client_only_mask to all ones;
// payload ready drops only when the four-entry record queue is full, so the
// output side may stall without back-pressuring the byte stream straight away
module delta_payload_record_parser #(
  parameter int NUM_TYPES = 64
) (
  input logic           clk,
  input logic           rst,
  dprp_payload_if.sink  payload,
  dprp_record_if.source records,
  dprp_cfg_if.sink      cfg
);
  import dprp_pkg::*;

  // front to queue
  logic    push;
  rec_t    push_rec;
  logic    q_full;

  // queue to back
  q_head_t q_head;
  logic    pop;

  // front parser: header assembly, type filtering, record forming
  dprp_front #(
    .NUM_TYPES (NUM_TYPES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .payload  (payload),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  // short record queue decoupling parser from the output handshake
  dprp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full)
  );

  // output register driving the record channel
  dprp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .pop     (pop),
    .records (records)
  );

endmodule
